/* hdl/nfc_normal_frame_builder_core_assert.svh */
// Assertion helpers shared by the frame builder modules.
`ifndef NFC_NORMAL_FRAME_BUILDER_CORE_ASSERT_SVH
`define NFC_NORMAL_FRAME_BUILDER_CORE_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define NFC_FB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition must never be seen outside reset.
`define NFC_FB_NEVER(name, clk, rst_n, cond, msg) \
  `NFC_FB_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

/* hdl/nfc_fb_pkg.sv */
package nfc_fb_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_PAYLOAD_DEF = 254;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Status codes on the result channel
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

  // Frame constants
  localparam logic [7:0] TFI_HOST   = 8'hD4;
  localparam logic [7:0] DCS_INIT   = 8'h2C;
  localparam logic [7:0] START_CODE = 8'hFF;
  localparam logic [7:0] PAD_BYTE   = 8'h00;

  // Emitter step positions within a frame
  localparam logic [2:0] STEP_PRE0  = 3'd0;
  localparam logic [2:0] STEP_PRE1  = 3'd1;
  localparam logic [2:0] STEP_START = 3'd2;
  localparam logic [2:0] STEP_LEN   = 3'd3;
  localparam logic [2:0] STEP_LCS   = 3'd4;
  localparam logic [2:0] STEP_DATA  = 3'd5;
  localparam logic [2:0] STEP_CHK   = 3'd6;
  localparam logic [2:0] STEP_POST  = 3'd7;

  // Input item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_DATA = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] status;
  } out_item_t;

  // Classified work handed from front to back
  typedef struct packed {
    cmd_kind_e  kind;
    logic [1:0] status;
    logic [2:0] first_step;
    logic [7:0] data;
    logic [7:0] chk;
    logic       tail;
  } cmd_t;

endpackage

/* hdl/nfc_fb_front.sv */
module nfc_fb_front #(
  parameter int unsigned MAX_PAYLOAD = nfc_fb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  nfc_fb_pkg::in_item_t in_item_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output nfc_fb_pkg::cmd_t     q_cmd_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic [7:0] remaining_q, remaining_d;
  logic [7:0] checksum_q, checksum_d;
  logic       open_q, open_d;
  logic [7:0] lenf;
  logic [7:0] new_chk;

  assign q_push_o = push_i && !q_full_i;
  assign lenf     = in_item_i.payload_length + 8'd1;
  assign new_chk  = checksum_q - in_item_i.payload_byte;

  // Classify the beat and work out the frame state after it
  always_comb begin
    remaining_d        = remaining_q;
    checksum_d         = checksum_q;
    open_d             = open_q;
    q_cmd_o.kind       = nfc_fb_pkg::CMD_ERR;
    q_cmd_o.status     = nfc_fb_pkg::STATUS_OK;
    q_cmd_o.first_step = nfc_fb_pkg::STEP_DATA;
    q_cmd_o.data       = in_item_i.payload_byte;
    q_cmd_o.chk        = nfc_fb_pkg::DCS_INIT;
    q_cmd_o.tail       = 1'b0;
    if (in_item_i.mode == nfc_fb_pkg::MODE_START) begin
      remaining_d = 8'd0;
      checksum_d  = nfc_fb_pkg::DCS_INIT;
      open_d      = 1'b0;
      if (in_item_i.payload_length > MaxLen) begin
        q_cmd_o.status = nfc_fb_pkg::STATUS_TOO_LONG;
      end else begin
        q_cmd_o.kind       = nfc_fb_pkg::CMD_HDR;
        q_cmd_o.first_step = nfc_fb_pkg::STEP_PRE0;
        q_cmd_o.data       = lenf;
        q_cmd_o.tail       = (in_item_i.payload_length == 8'd0);
        open_d             = (in_item_i.payload_length != 8'd0);
        remaining_d        = in_item_i.payload_length;
      end
    end else if (!open_q) begin
      q_cmd_o.status = nfc_fb_pkg::STATUS_NO_FRAME;
    end else begin
      q_cmd_o.kind = nfc_fb_pkg::CMD_DATA;
      q_cmd_o.chk  = new_chk;
      q_cmd_o.tail = (remaining_q == 8'd1);
      remaining_d  = remaining_q - 8'd1;
      checksum_d   = new_chk;
      if (remaining_q == 8'd1) begin
        // final payload byte closes the frame
        remaining_d = 8'd0;
        checksum_d  = nfc_fb_pkg::DCS_INIT;
        open_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= 8'd0;
      checksum_q  <= nfc_fb_pkg::DCS_INIT;
      open_q      <= 1'b0;
    end else if (q_push_o) begin
      remaining_q <= remaining_d;
      checksum_q  <= checksum_d;
      open_q      <= open_d;
    end
  end

endmodule

/* hdl/nfc_fb_queue.sv */
`include "nfc_normal_frame_builder_core_assert.svh"

module nfc_fb_queue #(
  parameter int unsigned DEPTH = nfc_fb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nfc_fb_pkg::cmd_t cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output nfc_fb_pkg::cmd_t cmd_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);
  localparam logic [AW-1:0] Last = AW'(DEPTH - 1);

  nfc_fb_pkg::cmd_t slot_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == Full);
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == Last) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == Last) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  `NFC_FB_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "queue push while full")
  `NFC_FB_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "queue pop while empty")
  `NFC_FB_NEVER(a_count_range, clk_i, rst_ni, count_q > Full, "queue count out of range")

endmodule

/* hdl/nfc_fb_back.sv */
`include "nfc_normal_frame_builder_core_assert.svh"

module nfc_fb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  nfc_fb_pkg::cmd_t      q_cmd_i,
  output logic                  q_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output nfc_fb_pkg::out_item_t out_item_o
);

  nfc_fb_pkg::cmd_t cur_q, cur_d;
  logic [2:0] step_q, step_d;
  logic       valid_q, valid_d;
  logic [2:0] end_step;
  logic       beat_done;
  logic       cmd_done;

  assign empty_o = !valid_q;

  // Last step of the command in flight
  always_comb begin
    if (cur_q.kind == nfc_fb_pkg::CMD_ERR) begin
      end_step = cur_q.first_step;
    end else if (cur_q.tail) begin
      end_step = nfc_fb_pkg::STEP_POST;
    end else begin
      end_step = nfc_fb_pkg::STEP_DATA;
    end
  end

  assign beat_done = valid_q && pop_i;
  assign cmd_done  = beat_done && (step_q == end_step);
  assign q_pop_o   = (!valid_q || cmd_done) && !q_empty_i;

  // Step sequencing and command load
  always_comb begin
    cur_d   = cur_q;
    step_d  = step_q;
    valid_d = valid_q;
    if (q_pop_o) begin
      cur_d   = q_cmd_i;
      step_d  = q_cmd_i.first_step;
      valid_d = 1'b1;
    end else if (cmd_done) begin
      valid_d = 1'b0;
    end else if (beat_done) begin
      step_d = step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= nfc_fb_pkg::STEP_PRE0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // Result beat from the current command and step
  always_comb begin
    out_item_o.frame_byte = nfc_fb_pkg::PAD_BYTE;
    out_item_o.last_byte  = 1'b0;
    out_item_o.status     = nfc_fb_pkg::STATUS_OK;
    if (cur_q.kind == nfc_fb_pkg::CMD_ERR) begin
      out_item_o.last_byte = 1'b1;
      out_item_o.status    = cur_q.status;
    end else begin
      case (step_q)
        nfc_fb_pkg::STEP_PRE0:  out_item_o.frame_byte = nfc_fb_pkg::PAD_BYTE;
        nfc_fb_pkg::STEP_PRE1:  out_item_o.frame_byte = nfc_fb_pkg::PAD_BYTE;
        nfc_fb_pkg::STEP_START: out_item_o.frame_byte = nfc_fb_pkg::START_CODE;
        nfc_fb_pkg::STEP_LEN:   out_item_o.frame_byte = cur_q.data;
        nfc_fb_pkg::STEP_LCS:   out_item_o.frame_byte = 8'd0 - cur_q.data;
        nfc_fb_pkg::STEP_DATA: begin
          out_item_o.frame_byte = (cur_q.kind == nfc_fb_pkg::CMD_HDR) ?
                                  nfc_fb_pkg::TFI_HOST : cur_q.data;
        end
        nfc_fb_pkg::STEP_CHK:   out_item_o.frame_byte = cur_q.chk;
        nfc_fb_pkg::STEP_POST: begin
          out_item_o.frame_byte = nfc_fb_pkg::PAD_BYTE;
          out_item_o.last_byte  = 1'b1;
        end
        default:                out_item_o.frame_byte = nfc_fb_pkg::PAD_BYTE;
      endcase
    end
  end

  `NFC_FB_NEVER(a_step_in_range, clk_i, rst_ni, valid_q && (step_q > end_step), "step past end")
  `NFC_FB_ASSERT(a_load_step, clk_i, rst_ni, q_pop_o |=> step_q == $past(q_cmd_i.first_step), "bad load")
  `NFC_FB_NEVER(a_err_last, clk_i, rst_ni, valid_q && (out_item_o.status != nfc_fb_pkg::STATUS_OK) && !out_item_o.last_byte, "error beat not last")

endmodule

/* hdl/nfc_normal_frame_builder_core.sv */
// Normal information frame builder, host to reader direction.
// Input channel (push_i/full_o): a beat with mode 0 starts a frame of
// payload_length bytes; a beat with mode 1 carries one payload byte.
// Result channel (empty_o/pop_i): one beat per frame byte. A start gives
// 00 00 FF LEN LCS D4; each payload byte is passed through; the last byte of
// the frame (or a zero length start) adds the data checksum and a 00
// postamble with last_byte set. Errors give one beat of 0, last, with status.
// An input beat taken while the emitter is free is written to the queue and
// then loaded into the emitter, which drives the result ports. Payload bytes
// sustain one beat per cycle while the receiver pops; a header holds the
// emitter for its whole sequence, during which the command queue (QUEUE_DEPTH
// entries) absorbs input beats. full_o rises only when that queue fills, so
// a stalled receiver (pop_i low) back-pressures the input after QUEUE_DEPTH
// beats beyond the one held in the emitter; nothing is dropped.
// Reset clears the frame state (no frame open, checksum 0x2C), the queue
// and the emitter; no result is pending after reset.
module nfc_normal_frame_builder_core #(
  parameter int unsigned MAX_PAYLOAD = nfc_fb_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned QUEUE_DEPTH = nfc_fb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  nfc_fb_pkg::in_item_t  in_item_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output nfc_fb_pkg::out_item_t out_item_o
);

  logic             q_push, q_pop, q_full, q_empty;
  nfc_fb_pkg::cmd_t push_cmd, head_cmd;

  assign full_o = q_full;

  nfc_fb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .in_item_i(in_item_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  nfc_fb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .cmd_o  (head_cmd)
  );

  nfc_fb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (q_pop),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .out_item_o(out_item_o)
  );

endmodule

/* dv/nfc_normal_frame_builder_core_test.sv */
module nfc_normal_frame_builder_core_test;
  import nfc_fb_pkg::*;

  localparam int unsigned MAX_LEN       = MAX_PAYLOAD_DEF;
  localparam int unsigned ITEM_TARGET   = 480;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 24;

  logic      clk_i;
  logic      rst_ni;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_item = '0;
  out_item_t out_item;

  // Stimulus and expected frame bytes
  in_item_t  items_to_send[$];
  out_item_t frame_bytes_due[$];
  int        items_total;
  int        items_sent = 0;
  int        mismatches = 0;
  int        stall_cycles = 0;
  int        send_idle_pct;
  int        recv_idle_pct;

  // Predicted frame state
  logic       frame_open_m;
  logic [7:0] bytes_left_m;
  logic [7:0] checksum_m;

  nfc_normal_frame_builder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void add_item(input logic mode, input logic [7:0] len,
                                   input logic [7:0] data);
    in_item_t it;
    it.mode = mode;
    it.payload_length = len;
    it.payload_byte = data;
    items_to_send.push_back(it);
  endfunction

  function automatic void emit_byte(input logic [7:0] data, input logic last,
                                    input logic [1:0] status);
    out_item_t o;
    o.frame_byte = data;
    o.last_byte = last;
    o.status = status;
    frame_bytes_due.push_back(o);
  endfunction

  function automatic void close_frame();
    emit_byte(checksum_m, 1'b0, STATUS_OK);
    emit_byte(PAD_BYTE, 1'b1, STATUS_OK);
    frame_open_m = 1'b0;
    bytes_left_m = '0;
    checksum_m = DCS_INIT;
  endfunction

  // Frame bytes caused by one accepted input beat
  function automatic void predict_frame_bytes(input in_item_t it);
    logic [7:0] len_field;
    if (it.mode == MODE_START) begin
      frame_open_m = 1'b0;
      bytes_left_m = '0;
      checksum_m = DCS_INIT;
      if (it.payload_length > MAX_LEN) begin
        emit_byte(PAD_BYTE, 1'b1, STATUS_TOO_LONG);
      end else begin
        len_field = it.payload_length + 8'd1;
        emit_byte(PAD_BYTE, 1'b0, STATUS_OK);
        emit_byte(PAD_BYTE, 1'b0, STATUS_OK);
        emit_byte(START_CODE, 1'b0, STATUS_OK);
        emit_byte(len_field, 1'b0, STATUS_OK);
        emit_byte(8'd0 - len_field, 1'b0, STATUS_OK);
        emit_byte(TFI_HOST, 1'b0, STATUS_OK);
        if (it.payload_length == 8'd0) begin
          close_frame();
        end else begin
          frame_open_m = 1'b1;
          bytes_left_m = it.payload_length;
        end
      end
    end else if (!frame_open_m) begin
      emit_byte(PAD_BYTE, 1'b1, STATUS_NO_FRAME);
    end else begin
      emit_byte(it.payload_byte, 1'b0, STATUS_OK);
      checksum_m = checksum_m - it.payload_byte;
      bytes_left_m = bytes_left_m - 8'd1;
      if (bytes_left_m == 8'd0) close_frame();
    end
  endfunction

  // Idle mix by progress: slow receiver, then slow sender, then full rate
  always_comb begin
    if (items_sent < items_total / 3) begin
      send_idle_pct = 25;
      recv_idle_pct = 75;
    end else if (items_sent < (2 * items_total) / 3) begin
      send_idle_pct = 75;
      recv_idle_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Driver: one beat per accepted push, held while full
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_frame_bytes(in_item);
        void'(items_to_send.pop_front());
        items_sent++;
      end
      if (!(push && full)) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          in_item <= items_to_send[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped beat with the oldest expected byte
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte=%h last=%b status=%0d",
                                    out_item.frame_byte, out_item.last_byte,
                                    out_item.status));
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_item.frame_byte !== want.frame_byte)
            report_mismatch($sformatf("frame_byte %h, want %h",
                                      out_item.frame_byte, want.frame_byte));
          if (out_item.last_byte !== want.last_byte)
            report_mismatch($sformatf("last_byte %b, want %b",
                                      out_item.last_byte, want.last_byte));
          if (out_item.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_item.status, want.status));
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Cycles without any beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    int         len;
    int         pick;
    int         sent_bytes;
    logic       big_done;
    frame_open_m = 1'b0;
    bytes_left_m = '0;
    checksum_m = DCS_INIT;
    big_done = 1'b0;

    // Directed: errors, zero length, restarts, length extremes
    add_item(MODE_BYTE, 8'hFF, 8'h5A);        // byte with nothing open
    add_item(MODE_START, 8'h00, 8'hFF);       // empty frame, whole thing at once
    add_item(MODE_START, 8'hFF, 8'h00);       // too long
    add_item(MODE_BYTE, 8'h00, 8'hA5);
    add_item(MODE_START, 8'h01, 8'h00);
    add_item(MODE_BYTE, 8'h00, 8'hFF);
    add_item(MODE_START, 8'h02, 8'hFF);
    add_item(MODE_BYTE, 8'hFF, 8'h00);
    add_item(MODE_BYTE, 8'h55, 8'h80);
    add_item(MODE_START, 8'h03, 8'h00);
    add_item(MODE_BYTE, 8'h00, 8'hAA);
    add_item(MODE_START, 8'h01, 8'h00);       // restart mid-frame
    add_item(MODE_BYTE, 8'h00, 8'h01);
    add_item(MODE_START, 8'h03, 8'h00);
    add_item(MODE_BYTE, 8'h00, 8'h11);
    add_item(MODE_START, 8'hFF, 8'h00);       // too long abandons open frame
    add_item(MODE_BYTE, 8'h00, 8'h22);
    add_item(MODE_START, 8'd253, 8'h00);
    add_item(MODE_START, 8'h00, 8'h00);
    add_item(MODE_START, 8'd254, 8'h00);      // LEN FF, LCS 01
    add_item(MODE_START, 8'h00, 8'h00);

    // Random: mostly well-formed frames, some noise and broken frames
    while (items_to_send.size() < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (!big_done && items_to_send.size() > ITEM_TARGET / 3) begin
        big_done = 1'b1;
        add_item(MODE_START, 8'(MAX_LEN), 8'($urandom));
        for (int i = 0; i < MAX_LEN; i++)
          add_item(MODE_BYTE, 8'($urandom), 8'($urandom));
      end else if (pick < 80) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        sent_bytes = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
        add_item(MODE_START, 8'(len), 8'($urandom));
        for (int i = 0; i < sent_bytes; i++)
          add_item(MODE_BYTE, 8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        add_item(MODE_BYTE, 8'($urandom), 8'($urandom));
      end else if (pick < 95) begin
        add_item(MODE_START, 8'hFF, 8'($urandom));
      end else begin
        add_item(MODE_START, 8'($urandom_range(255)), 8'($urandom));
      end
    end
    items_total = items_to_send.size();

    @(posedge rst_ni);
    while ((items_to_send.size() != 0 || frame_bytes_due.size() != 0)
           && stall_cycles < STALL_LIMIT)
      @(posedge clk_i);
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (mismatches == 0 && frame_bytes_due.size() == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/nfc_fb_pkg.sv
hdl/nfc_fb_front.sv
hdl/nfc_fb_queue.sv
hdl/nfc_fb_back.sv
hdl/nfc_normal_frame_builder_core.sv
dv/nfc_normal_frame_builder_core_test.sv
